@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent property checks, compiled out when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("property check failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ sv/mahd_pkg.sv @@
// ----------------------------------------------------------------------------
// mahd_pkg
// shared types, tables and constants of the mpeg audio header decoder
// ----------------------------------------------------------------------------
package mahd_pkg;

	// version codes
	localparam logic [1:0] VER_MPEG1  = 2'd0;
	localparam logic [1:0] VER_MPEG2  = 2'd1;
	localparam logic [1:0] VER_MPEG25 = 2'd2;

	// channel mode codes
	localparam logic [1:0] MODE_JOINT = 2'd1;

	localparam logic [10:0] SYNC_BITS   = 11'h7ff;
	localparam logic [3:0]  BR_IDX_BAD  = 4'hf;
	localparam logic [1:0]  FR_IDX_BAD  = 2'd3;
	localparam logic [1:0]  LAYER_RSVD  = 2'd0;
	localparam logic [31:0] TAG_BYTES   = 32'd128;

	// reciprocal of 125 scaled by 2^36, floor
	localparam int unsigned  M125_SHIFT = 36;
	localparam logic [29:0]  M125       = 30'd549755813;
	localparam logic [29:0]  RECIP_ONE  = 30'h2000_0000;	// 2^29
	localparam int unsigned  RECIP_SHIFT = 29;

	typedef struct packed {
		logic [31:0] header_word;
		logic [31:0] file_length;
		logic        has_tail_tag;
	} in_word_t;

	typedef struct packed {
		logic        header_ok;
		logic [1:0]  mpeg_version;
		logic [1:0]  layer_number;
		logic        crc_protected;
		logic [8:0]  bitrate_kbps;
		logic [15:0] sample_rate_hz;
		logic        padding_bit;
		logic [1:0]  channel_mode;
		logic [4:0]  joint_bands;
		logic [4:0]  misc_flags;
		logic [22:0] play_seconds;
	} out_word_t;

	// bitrate in kbit/s: [index][lower sampling freq][layer - 1]
	localparam logic [8:0] RATE_TAB [16][2][4] = '{
		'{'{9'd0,   9'd0,   9'd0,   9'd0}, '{9'd0,   9'd0,   9'd0,   9'd0}},
		'{'{9'd32,  9'd32,  9'd32,  9'd0}, '{9'd32,  9'd8,   9'd8,   9'd0}},
		'{'{9'd64,  9'd48,  9'd40,  9'd0}, '{9'd48,  9'd16,  9'd16,  9'd0}},
		'{'{9'd96,  9'd56,  9'd48,  9'd0}, '{9'd56,  9'd24,  9'd24,  9'd0}},
		'{'{9'd128, 9'd64,  9'd56,  9'd0}, '{9'd64,  9'd32,  9'd32,  9'd0}},
		'{'{9'd160, 9'd80,  9'd64,  9'd0}, '{9'd80,  9'd40,  9'd40,  9'd0}},
		'{'{9'd192, 9'd96,  9'd80,  9'd0}, '{9'd96,  9'd48,  9'd48,  9'd0}},
		'{'{9'd224, 9'd112, 9'd96,  9'd0}, '{9'd112, 9'd56,  9'd56,  9'd0}},
		'{'{9'd256, 9'd128, 9'd112, 9'd0}, '{9'd128, 9'd64,  9'd64,  9'd0}},
		'{'{9'd288, 9'd160, 9'd128, 9'd0}, '{9'd144, 9'd80,  9'd80,  9'd0}},
		'{'{9'd320, 9'd192, 9'd160, 9'd0}, '{9'd160, 9'd96,  9'd96,  9'd0}},
		'{'{9'd352, 9'd224, 9'd192, 9'd0}, '{9'd176, 9'd112, 9'd112, 9'd0}},
		'{'{9'd384, 9'd256, 9'd224, 9'd0}, '{9'd192, 9'd128, 9'd128, 9'd0}},
		'{'{9'd416, 9'd320, 9'd256, 9'd0}, '{9'd224, 9'd144, 9'd144, 9'd0}},
		'{'{9'd448, 9'd384, 9'd320, 9'd0}, '{9'd256, 9'd160, 9'd160, 9'd0}},
		'{'{9'd0,   9'd0,   9'd0,   9'd0}, '{9'd0,   9'd0,   9'd0,   9'd0}}
	};

	// sample rate in hz: [version][rate index]
	localparam logic [15:0] FREQ_TAB [4][4] = '{
		'{16'd44100, 16'd48000, 16'd32000, 16'd0},
		'{16'd22050, 16'd24000, 16'd16000, 16'd0},
		'{16'd11025, 16'd12000, 16'd8000,  16'd0},
		'{16'd0,     16'd0,     16'd0,     16'd0}
	};

	// joint stereo band bound: [layer - 1][mode extension]
	localparam logic [4:0] BAND_TAB [4][4] = '{
		'{5'd4, 5'd8, 5'd12, 5'd16},
		'{5'd4, 5'd8, 5'd12, 5'd16},
		'{5'd0, 5'd4, 5'd8,  5'd16},
		'{5'd0, 5'd0, 5'd0,  5'd0}
	};

	// floor(2^29 / k) for every k = kbps / 8 the rate table can give
	function automatic logic [29:0] recip(input logic [5:0] k);
		logic [29:0] r;
		case (k)
			6'd1:    r = RECIP_ONE;
			6'd2:    r = RECIP_ONE / 2;
			6'd3:    r = RECIP_ONE / 3;
			6'd4:    r = RECIP_ONE / 4;
			6'd5:    r = RECIP_ONE / 5;
			6'd6:    r = RECIP_ONE / 6;
			6'd7:    r = RECIP_ONE / 7;
			6'd8:    r = RECIP_ONE / 8;
			6'd10:   r = RECIP_ONE / 10;
			6'd12:   r = RECIP_ONE / 12;
			6'd14:   r = RECIP_ONE / 14;
			6'd16:   r = RECIP_ONE / 16;
			6'd18:   r = RECIP_ONE / 18;
			6'd20:   r = RECIP_ONE / 20;
			6'd22:   r = RECIP_ONE / 22;
			6'd24:   r = RECIP_ONE / 24;
			6'd28:   r = RECIP_ONE / 28;
			6'd32:   r = RECIP_ONE / 32;
			6'd36:   r = RECIP_ONE / 36;
			6'd40:   r = RECIP_ONE / 40;
			6'd44:   r = RECIP_ONE / 44;
			6'd48:   r = RECIP_ONE / 48;
			6'd52:   r = RECIP_ONE / 52;
			6'd56:   r = RECIP_ONE / 56;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/mpeg_audio_header_decoder.sv @@
// throughput: one word per cycle while out_ready is high, set by the six-stage
// pipeline (decode, two reciprocal multiplies with correction steps, output
// register); stalled output holds its word; empty stages still take new words
// reset: arst_n clears all stage valid bits asynchronously, no words in flight
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder
// checks one candidate mpeg audio frame header per word, decodes its fields
// and estimates play time in whole seconds
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpeg_audio_header_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mahd_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output mahd_pkg::out_word_t out_word
);

	// stage 1: decode result, registered
	mahd_pkg::out_word_t dec_fields;
	logic [28:0]         dec_x;
	logic [5:0]          dec_k;

	logic                v_s1;
	logic                rdy_s1;
	mahd_pkg::out_word_t f_s1;
	logic [28:0]         x_s1;
	logic [5:0]          k_s1;
	logic                div_ready;

	mahd_decode u_decode (
		.in_word   (in_word),
		.fields    (dec_fields),
		.body_div8 (dec_x),
		.rate_div  (dec_k)
	);

	// stage 1 loads whenever it is empty or the divider takes its word
	assign rdy_s1   = !v_s1 || div_ready;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			f_s1 <= dec_fields;
			x_s1 <= dec_x;
			k_s1 <= dec_k;
		end
	end

	// stages 2..6: body / 1000 by reciprocal of 125 on body / 8, then / k
	// by a table reciprocal; each product gets one correction step
	mahd_secs u_secs (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (div_ready),
		.in_x      (x_s1),
		.in_k      (k_s1),
		.in_fields (f_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	// an accepted word always lands in stage 1
	`ASSERT_PROP(a_accept_lands, clk, arst_n, (in_valid && in_ready) |=> v_s1)

	// a rejected header carries nothing but zeros
	`ASSERT_NEVER(a_bad_hdr_zero, clk, arst_n,
		out_valid && !out_word.header_ok && (out_word != '0))

	// free format or no bitrate means no play time
	`ASSERT_NEVER(a_free_no_time, clk, arst_n,
		out_valid && (out_word.bitrate_kbps == 9'd0) && (out_word.play_seconds != 23'd0))

	// a valid header always decodes a layer and a sample rate
	`ASSERT_NEVER(a_ok_fields, clk, arst_n,
		out_valid && out_word.header_ok &&
		((out_word.layer_number == 2'd0) || (out_word.sample_rate_hz == 16'd0)))

endmodule

@@ sv/mahd_decode.sv @@
// ----------------------------------------------------------------------------
// mahd_decode
// header checks, field extraction, table lookups and tag removal
// ----------------------------------------------------------------------------
module mahd_decode (
	input  mahd_pkg::in_word_t  in_word,
	output mahd_pkg::out_word_t fields,
	output logic [28:0]         body_div8,
	output logic [5:0]          rate_div
);

	logic [31:0] w;
	logic        ok;
	logic [1:0]  lay_bits;
	logic [3:0]  br_idx;
	logic [1:0]  fr_idx;
	logic [1:0]  ver;
	logic [1:0]  layer;
	logic [1:0]  lidx;
	logic        lsf;
	logic [8:0]  kbps;
	logic [1:0]  mode;
	logic [31:0] body;

	always_comb begin
		w        = in_word.header_word;
		lay_bits = w[18:17];
		br_idx   = w[15:12];
		fr_idx   = w[11:10];
		ok = (w[31:21] == mahd_pkg::SYNC_BITS) && (lay_bits != mahd_pkg::LAYER_RSVD) &&
			(br_idx != mahd_pkg::BR_IDX_BAD) && (fr_idx != mahd_pkg::FR_IDX_BAD);

		// bit 20 clear means mpeg 2.5, reserved code included
		if (w[20]) begin
			ver = w[19] ? mahd_pkg::VER_MPEG1 : mahd_pkg::VER_MPEG2;
		end else begin
			ver = mahd_pkg::VER_MPEG25;
		end
		layer = 2'(3'd4 - {1'b0, lay_bits});
		lidx  = layer - 2'd1;
		lsf   = (ver != mahd_pkg::VER_MPEG1);
		kbps  = mahd_pkg::RATE_TAB[br_idx][lsf][lidx];
		mode  = w[7:6];

		if (in_word.has_tail_tag) begin
			body = (in_word.file_length >= mahd_pkg::TAG_BYTES) ?
				in_word.file_length - mahd_pkg::TAG_BYTES : '0;
		end else begin
			body = in_word.file_length;
		end

		fields    = '0;
		body_div8 = '0;
		rate_div  = '0;
		if (ok) begin
			fields.header_ok      = 1'b1;
			fields.mpeg_version   = ver;
			fields.layer_number   = layer;
			fields.crc_protected  = ~w[16];
			fields.bitrate_kbps   = kbps;
			fields.sample_rate_hz = mahd_pkg::FREQ_TAB[ver][fr_idx];
			fields.padding_bit    = w[9];
			fields.channel_mode   = mode;
			fields.joint_bands    = (mode == mahd_pkg::MODE_JOINT) ?
				mahd_pkg::BAND_TAB[lidx][w[5:4]] : 5'd0;
			fields.misc_flags     = {w[8], w[3], w[2], w[1:0]};
			body_div8             = body[31:3];
			// every table rate is a multiple of 8 kbit/s
			rate_div              = kbps[8:3];
		end
	end

endmodule

@@ sv/mahd_secs.sv @@
// ----------------------------------------------------------------------------
// mahd_secs
// five-stage play time divider: floor(floor(body / 1000) / k), k = kbps / 8
// ----------------------------------------------------------------------------
module mahd_secs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [28:0]         in_x,
	input  logic [5:0]          in_k,
	input  mahd_pkg::out_word_t in_fields,
	output logic                out_valid,
	input  logic                out_ready,
	output mahd_pkg::out_word_t out_word
);

	logic v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	logic [58:0]         p1_s2;
	logic [28:0]         x_s2;
	logic [5:0]          k_s2, k_s3, k_s4, k_s5;
	mahd_pkg::out_word_t f_s2, f_s3, f_s4, f_s5, f_s6;
	logic [22:0]         q_s3, q_s4, q_s5;
	logic [52:0]         p2_s4;
	logic [22:0]         e2_s5;
	logic [28:0]         pk_s5;

	logic [22:0] e1;
	logic [29:0] e1x125;
	logic [29:0] r1;
	logic [22:0] q_d;
	logic [22:0] e2_d;
	logic [28:0] r2;
	logic [22:0] secs_d;
	mahd_pkg::out_word_t f_d;

	assign rdy_s6   = !v_s6 || out_ready;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	// estimate may be one low, one correction step fixes it
	always_comb begin
		e1     = p1_s2[mahd_pkg::M125_SHIFT +: 23];
		// e1 * 125 as e1 * 128 - e1 * 4 + e1
		e1x125 = {e1, 7'd0} - {5'd0, e1, 2'd0} + {7'd0, e1};
		r1     = {1'b0, x_s2} - e1x125;
		q_d    = (r1 >= 30'd125) ? e1 + 23'd1 : e1;
		e2_d   = p2_s4[mahd_pkg::RECIP_SHIFT +: 23];
		r2     = {6'd0, q_s5} - pk_s5;
		if (k_s5 == 6'd0) begin
			secs_d = '0;
		end else begin
			secs_d = (r2 >= {23'd0, k_s5}) ? e2_s5 + 23'd1 : e2_s5;
		end
		f_d              = f_s5;
		f_d.play_seconds = secs_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			p1_s2 <= 59'(in_x * mahd_pkg::M125);
			x_s2  <= in_x;
			k_s2  <= in_k;
			f_s2  <= in_fields;
		end
		if (rdy_s3 && v_s2) begin
			q_s3 <= q_d;
			k_s3 <= k_s2;
			f_s3 <= f_s2;
		end
		if (rdy_s4 && v_s3) begin
			p2_s4 <= 53'(q_s3 * mahd_pkg::recip(k_s3));
			q_s4  <= q_s3;
			k_s4  <= k_s3;
			f_s4  <= f_s3;
		end
		if (rdy_s5 && v_s4) begin
			e2_s5 <= e2_d;
			pk_s5 <= 29'(e2_d * k_s4);
			q_s5  <= q_s4;
			k_s5  <= k_s4;
			f_s5  <= f_s4;
		end
		if (rdy_s6 && v_s5) begin
			f_s6 <= f_d;
		end
	end

	assign out_valid = v_s6;
	assign out_word  = f_s6;

endmodule
